>>> rtl/led_brc_pkg.sv
// Shared types and constants of the LED blink-rate classifier.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package led_brc_pkg;

    // Width of one configuration register and of the write port index.
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    // 3 * steady time needs two more bits than the register itself.
    localparam int STEADY3_W = CFG_W + 2;
    // Width of the reported pulse length field.
    localparam int PULSE_W   = 20;
    // Packed beat widths on the stream ports.
    localparam int IN_W      = 8;
    localparam int OUT_W     = 24;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEADY    = 3'd4;

    // Reset values of the registers.
    localparam logic [CFG_W-1:0] RST_IGNORE    = 16'd50;
    localparam logic [CFG_W-1:0] RST_FAST      = 16'd100;
    localparam logic [CFG_W-1:0] RST_SLOW      = 16'd1000;
    localparam logic [CFG_W-1:0] RST_TOLERANCE = 16'd20;
    localparam logic [CFG_W-1:0] RST_STEADY    = 16'd1200;
    localparam logic [STEADY3_W-1:0] RST_STEADY3 = 18'd3600;

    typedef enum logic [2:0] {
        MODE_OFF     = 3'd0,
        MODE_SLOW    = 3'd1,
        MODE_FAST    = 3'd2,
        MODE_ON      = 3'd3,
        MODE_UNKNOWN = 3'd4
    } t_mode;

    typedef struct packed {
        logic [CFG_W-1:0]     ignore_ms;
        logic [CFG_W-1:0]     fast_period_ms;
        logic [CFG_W-1:0]     slow_period_ms;
        logic [CFG_W-1:0]     tolerance_ms;
        logic [CFG_W-1:0]     steady_ms;
        logic [STEADY3_W-1:0] steady_x3_ms;
    } t_cfg;

endpackage

>>> rtl/led_brc_cfg.sv
// Configuration register file of the LED blink-rate classifier.
// Depends on led_brc_pkg; also keeps three times the steady time ready.
`timescale 1ns / 1ps

module led_brc_cfg
    import led_brc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IGNORE:    n_cfg.ignore_ms      = i_cfg_wdata;
                CFG_FAST:      n_cfg.fast_period_ms = i_cfg_wdata;
                CFG_SLOW:      n_cfg.slow_period_ms = i_cfg_wdata;
                CFG_TOLERANCE: n_cfg.tolerance_ms   = i_cfg_wdata;
                CFG_STEADY: begin
                    n_cfg.steady_ms    = i_cfg_wdata;
                    n_cfg.steady_x3_ms = {1'b0, i_cfg_wdata, 1'b0}
                                       + {2'b00, i_cfg_wdata};
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ignore_ms      <= RST_IGNORE;
            r_cfg.fast_period_ms <= RST_FAST;
            r_cfg.slow_period_ms <= RST_SLOW;
            r_cfg.tolerance_ms   <= RST_TOLERANCE;
            r_cfg.steady_ms      <= RST_STEADY;
            r_cfg.steady_x3_ms   <= RST_STEADY3;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/led_brc_step.sv
// Per-tick next-state and result logic of the LED blink-rate classifier.
// Depends on led_brc_pkg; purely combinational, fed from registered state.
`timescale 1ns / 1ps

module led_brc_step
    import led_brc_pkg::*;
#(
    parameter int TIME_BITS = 20
) (
    input  t_cfg                 i_cfg,
    input  logic                 i_level,
    input  logic [TIME_BITS-1:0] i_elapsed,
    input  logic [TIME_BITS-1:0] i_last_pulse,
    input  logic                 i_prior_level,
    input  t_mode                i_mode,
    output logic [TIME_BITS-1:0] o_elapsed,
    output logic [TIME_BITS-1:0] o_last_pulse,
    output t_mode                o_mode,
    output logic                 o_changed,
    output logic                 o_edge_taken,
    output logic [PULSE_W-1:0]   o_pulse_out
);

    // True when the pulse lies strictly within the tolerance of the nominal length.
    function automatic logic near_nominal(input logic [TIME_BITS-1:0] pulse,
                                          input logic [CFG_W-1:0]     nominal,
                                          input logic [CFG_W-1:0]     tol);
        logic [TIME_BITS-1:0] nom;
        logic [TIME_BITS-1:0] diff;
        nom  = TIME_BITS'(nominal);
        diff = (pulse >= nom) ? (pulse - nom) : (nom - pulse);
        return diff < TIME_BITS'(tol);
    endfunction

    logic [TIME_BITS-1:0] w_now;
    t_mode                w_mode;

    // Saturating millisecond count.
    assign w_now = (&i_elapsed) ? i_elapsed : i_elapsed + 1'b1;

    assign o_edge_taken = (i_level != i_prior_level) &&
                          (w_now > TIME_BITS'(i_cfg.ignore_ms));
    assign o_last_pulse = o_edge_taken ? w_now : i_last_pulse;
    assign o_elapsed    = o_edge_taken ? '0 : w_now;

    always_comb begin
        w_mode = i_mode;
        if (o_edge_taken) begin
            if (near_nominal(o_last_pulse, i_cfg.fast_period_ms, i_cfg.tolerance_ms)) begin
                w_mode = MODE_FAST;
            end else if (near_nominal(o_last_pulse, i_cfg.slow_period_ms,
                                      i_cfg.tolerance_ms)) begin
                w_mode = MODE_SLOW;
            end
        end
        if ((o_elapsed > TIME_BITS'(i_cfg.steady_ms)) &&
            (o_elapsed < TIME_BITS'(i_cfg.steady_x3_ms))) begin
            w_mode = i_level ? MODE_OFF : MODE_ON;
        end
    end

    assign o_mode    = w_mode;
    assign o_changed = (w_mode != i_mode);

    generate
        if (TIME_BITS > PULSE_W) begin : g_sat
            assign o_pulse_out = (|o_last_pulse[TIME_BITS-1:PULSE_W]) ? '1
                               : o_last_pulse[PULSE_W-1:0];
        end else begin : g_ext
            assign o_pulse_out = PULSE_W'(o_last_pulse);
        end
    endgenerate

endmodule

>>> rtl/led_blink_rate_classifier.sv
// Top level of the LED blink-rate classifier: stream ports, pipeline and state.
// Depends on led_brc_pkg, led_brc_cfg and led_brc_step.
`timescale 1ns / 1ps

// The block takes one beat per millisecond tick carrying the sampled LED sense
// level (active low: 0 means lit) and returns exactly one result beat per input
// beat, holding the LED mode (0 off, 1 slow blink, 2 fast blink, 3 on,
// 4 unknown), a flag that the mode changed on this tick, and the length in ms
// of the last accepted pulse, saturated to 20 bits. Level changes no more than
// ignore_ms after the last accepted change are dropped; an accepted pulse within
// tolerance_ms of the fast or slow period selects that blink mode, and a quiet
// time strictly between steady_ms and three times steady_ms reports steady on
// or off. The block accepts one beat every clock cycle unless a result waits
// on the output side while another beat sits in the input register; each beat
// is registered in the input register and then resolved in a single pass of
// compare and add logic on the state registers into the result register. The
// result register lets a new beat enter while an earlier result waits on the
// output side. Configuration writes take effect on the next cycle and must be
// made only while no beat is in flight.

module led_blink_rate_classifier
    import led_brc_pkg::*;
#(
    parameter int TIME_BITS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // Input stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,   // [0] led_level, [7:1] zero
    // Result stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata    // [2:0] led_mode, [3] mode_changed,
                                                 // [23:4] pulse_length
);

    t_cfg w_cfg;

    led_brc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // Input register stage.
    logic r_in_valid;
    logic r_in_level;

    // Classifier state, updated whenever a beat moves into the result register.
    logic [TIME_BITS-1:0] r_elapsed;
    logic [TIME_BITS-1:0] r_last_pulse;
    logic                 r_prior_level;
    t_mode                r_mode;

    // Result register stage.
    logic                 r_out_valid;
    t_mode                r_out_mode;
    logic                 r_out_changed;
    logic [PULSE_W-1:0]   r_out_pulse;

    logic [TIME_BITS-1:0] n_elapsed;
    logic [TIME_BITS-1:0] n_last_pulse;
    t_mode                n_mode;
    logic                 n_changed;
    logic                 w_edge_taken;
    logic [PULSE_W-1:0]   n_pulse;

    // A beat advances from the input register when the result register is
    // empty or is being emptied in this cycle.
    logic w_adv;
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    led_brc_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .i_cfg         (w_cfg),
        .i_level       (r_in_level),
        .i_elapsed     (r_elapsed),
        .i_last_pulse  (r_last_pulse),
        .i_prior_level (r_prior_level),
        .i_mode        (r_mode),
        .o_elapsed     (n_elapsed),
        .o_last_pulse  (n_last_pulse),
        .o_mode        (n_mode),
        .o_changed     (n_changed),
        .o_edge_taken  (w_edge_taken),
        .o_pulse_out   (n_pulse)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_level <= s_axis_tdata[0];
        end
    end

    // The reset state is LED dark, nothing counted, mode unknown.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed     <= '0;
            r_last_pulse  <= '0;
            r_prior_level <= 1'b1;
            r_mode        <= MODE_UNKNOWN;
        end else if (w_adv) begin
            r_elapsed     <= n_elapsed;
            r_last_pulse  <= n_last_pulse;
            r_prior_level <= r_in_level;
            r_mode        <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_mode    <= n_mode;
            r_out_changed <= n_changed;
            r_out_pulse   <= n_pulse;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_pulse, r_out_changed, r_out_mode};

    // The reported mode always matches the live mode state, since both load
    // on the same beat.
    a_mode_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_mode == r_mode))
        else $error("result mode differs from mode state");

    // An accepted level change restarts the elapsed counter.
    a_edge_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_edge_taken) |=> (r_elapsed == '0))
        else $error("elapsed counter not restarted after accepted edge");

    // The input side only stalls while a beat is held in the input register.
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled without a held beat");

endmodule

>>> tb/led_brc_checker.sv
// Scoreboard for the LED blink-rate classifier: follows the register writes,
// predicts one report per accepted tick beat and compares it with the result beats.
// Depends on led_brc_pkg for the register indexes, reset values and mode codes.
`timescale 1ns / 1ps

module led_brc_checker
    import led_brc_pkg::*;
#(
    parameter int TIME_BITS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [IN_W-1:0]      i_in_data,    // [0] led_level, [7:1] zero
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [OUT_W-1:0]     i_out_data,   // [2:0] led_mode, [3] mode_changed,
                                               // [23:4] pulse_length
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam logic [TIME_BITS-1:0] ELAPSED_MAX = '1;
    localparam logic [TIME_BITS-1:0] PULSE_CLIP  = TIME_BITS'((1 << PULSE_W) - 1);

    typedef struct packed {
        t_mode              mode;
        logic               changed;
        logic [PULSE_W-1:0] pulse;
    } t_led_report;

    t_led_report expected_reports[$];
    int          mismatches = 0;

    // Register copies.
    logic [CFG_W-1:0] ignore_ms;
    logic [CFG_W-1:0] fast_ms;
    logic [CFG_W-1:0] slow_ms;
    logic [CFG_W-1:0] tolerance_ms;
    logic [CFG_W-1:0] steady_ms;

    // Classifier state.
    logic [TIME_BITS-1:0] elapsed_ms;
    logic [TIME_BITS-1:0] pulse_ms;
    logic                 prev_level;
    logic                 pulse_waiting;
    t_mode                mode_q;

    task automatic clear_state();
        ignore_ms     = RST_IGNORE;
        fast_ms       = RST_FAST;
        slow_ms       = RST_SLOW;
        tolerance_ms  = RST_TOLERANCE;
        steady_ms     = RST_STEADY;
        elapsed_ms    = '0;
        pulse_ms      = '0;
        prev_level    = 1'b1;
        pulse_waiting = 1'b0;
        mode_q        = MODE_UNKNOWN;
    endtask

    function automatic bit close_to(input logic [TIME_BITS-1:0] pulse,
                                    input logic [CFG_W-1:0] nominal);
        longint unsigned p;
        longint unsigned n;
        longint unsigned diff;
        p    = longint'(pulse);
        n    = longint'(nominal);
        diff = (p >= n) ? p - n : n - p;
        return diff < longint'(tolerance_ms);
    endfunction

    // One tick: edge stage first, then the polled update.
    task automatic advance_tick(input logic lvl, output t_led_report rep);
        logic [TIME_BITS-1:0] now;
        longint unsigned      steady_x3;
        t_mode                mode_before;
        mode_before = mode_q;
        now = elapsed_ms;
        if (now != ELAPSED_MAX) now = now + 1'b1;
        if (lvl != prev_level && now > ignore_ms) begin
            pulse_ms      = now;
            now           = '0;
            pulse_waiting = 1'b1;
        end
        elapsed_ms = now;
        prev_level = lvl;

        if (pulse_waiting) begin
            if (close_to(pulse_ms, fast_ms)) mode_q = MODE_FAST;
            else if (close_to(pulse_ms, slow_ms)) mode_q = MODE_SLOW;
            pulse_waiting = 1'b0;
        end
        steady_x3 = 3 * longint'(steady_ms);
        if (elapsed_ms > steady_ms && elapsed_ms < steady_x3)
            mode_q = lvl ? MODE_OFF : MODE_ON;

        rep.mode    = mode_q;
        rep.changed = (mode_q != mode_before);
        rep.pulse   = (pulse_ms > PULSE_CLIP) ? PULSE_W'(PULSE_CLIP) : PULSE_W'(pulse_ms);
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_led_report fresh;
        t_led_report want;
        if (!i_rst_n) begin
            clear_state();
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IGNORE:    ignore_ms    = i_cfg_wdata;
                    CFG_FAST:      fast_ms      = i_cfg_wdata;
                    CFG_SLOW:      slow_ms      = i_cfg_wdata;
                    CFG_TOLERANCE: tolerance_ms = i_cfg_wdata;
                    CFG_STEADY:    steady_ms    = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                advance_tick(i_in_data[0], fresh);
                expected_reports.push_back(fresh);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, i_out_data);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("led_mode", int'(want.mode), int'(i_out_data[2:0]));
                    check_field("mode_changed", int'(want.changed), int'(i_out_data[3]));
                    check_field("pulse_length", int'(want.pulse), int'(i_out_data[23:4]));
                end
            end
        end
        o_pending    <= expected_reports.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> tb/tb_top.sv
// Top of the LED blink-rate classifier testbench: clock, reset, register
// programming, tick stimulus, result back-pressure and the final verdict.
// Depends on led_brc_pkg, the block under test and tb/led_brc_checker.sv.
`timescale 1ns / 1ps

module tb_top;
    import led_brc_pkg::*;

    localparam int TIME_BITS        = 20;
    // Random part: several register settings, roughly a hundred ticks each.
    localparam int PHASES           = 8;
    localparam int TICKS_PER_PHASE  = 105;
    // In this phase the receiver stops for a long stretch while the sender keeps
    // offering beats back to back, so the block fills up and stalls its input.
    localparam int SQUEEZE_PHASE    = 4;
    localparam int SQUEEZE_TICKS    = 60;
    localparam int LONG_HOLD_CYCLES = 80;
    // Longest run of equal levels; keeps large register values from eating the run.
    localparam int MAX_RUN          = 150;
    localparam logic [CFG_W-1:0] REG_MAX = '1;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [CFG_W-1:0]     i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata  = '0;   // [0] led_level, [7:1] zero
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;         // [2:0] led_mode, [3] mode_changed,
                                                // [23:4] pulse_length

    int fail_count;
    int reports_pending;

    // Handshake between the stimulus and the receiver process. Both are written
    // with nonblocking assignments so the receiver always sees the prior value.
    int hold_requests = 0;
    bit calm_tail     = 1'b0;
    // Owned by the stimulus process alone.
    bit sender_gaps   = 1'b1;

    led_blink_rate_classifier #(
        .TIME_BITS(TIME_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    led_brc_checker #(
        .TIME_BITS(TIME_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_fail_count(fail_count),
        .o_pending   (reports_pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop. The slowest correct run is well under a tenth of this.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: random stall bursts, one long hold on request, and a steady ready
    // once the calm tail of the run has begun.
    initial begin : receiver
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = LONG_HOLD_CYCLES;
            end else if (hold_left == 0 && !calm_tail && $urandom_range(0, 9) == 0) begin
                hold_left = $urandom_range(1, 13);
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offers one tick beat and returns right after the edge that takes it.
    // Ready is looked at on the falling edge, where every signal has settled
    // to what the next rising edge will see.
    task automatic send_tick(input logic lvl);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - 1){1'b0}}, lvl};
        do begin
            @(negedge i_clk);
        end while (!s_axis_tready);
        @(posedge i_clk);
    endtask

    task automatic send_run(input logic lvl, input int len);
        repeat (len) send_tick(lvl);
    endtask

    // Stops offering beats and waits until every report has come back. The
    // first edge lets the scoreboard count a beat taken on the previous edge.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (reports_pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    // Writes all five registers back to back. With poke_unused set, the
    // indexes past the last register get random data, which must be dropped.
    task automatic program_registers(input logic [CFG_W-1:0] ign, input logic [CFG_W-1:0] fst,
                                     input logic [CFG_W-1:0] slw, input logic [CFG_W-1:0] tol,
                                     input logic [CFG_W-1:0] stdy, input bit poke_unused);
        cfg_write(CFG_IGNORE, ign);
        cfg_write(CFG_FAST, fst);
        cfg_write(CFG_SLOW, slw);
        cfg_write(CFG_TOLERANCE, tol);
        cfg_write(CFG_STEADY, stdy);
        if (poke_unused) begin
            for (int k = CFG_STEADY + 1; k < (1 << CFG_IDX_W); k++)
                cfg_write(CFG_IDX_W'(k), CFG_W'($urandom));
        end
        i_cfg_we <= 1'b0;
    endtask

    // Mostly a value from the useful range, now and then one of the extremes.
    function automatic logic [CFG_W-1:0] pick_reg(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 11);
        if (r == 0) return '0;
        if (r == 1) return REG_MAX;
        return CFG_W'($urandom_range(lo, hi));
    endfunction

    // Length of the next run of equal levels: most runs sit near the fast or
    // slow period, some fall into the steady window, the rest are glitches
    // at most one tick longer than the ignore time.
    function automatic int pick_run_len(input logic [CFG_W-1:0] ign, input logic [CFG_W-1:0] fst,
                                        input logic [CFG_W-1:0] slw, input logic [CFG_W-1:0] tol,
                                        input logic [CFG_W-1:0] stdy);
        int pick;
        int spread;
        int len;
        pick   = $urandom_range(0, 19);
        spread = (tol > 8) ? 9 : int'(tol) + 1;
        if (pick < 7)
            len = int'(fst) + int'($urandom_range(0, 2 * spread)) - spread;
        else if (pick < 13)
            len = int'(slw) + int'($urandom_range(0, 2 * spread)) - spread;
        else if (pick < 16)
            len = int'(stdy) + int'($urandom_range(1, 2 * int'(stdy) + 1));
        else
            len = int'($urandom_range(1, int'(ign) + 1));
        if (len < 1) len = 1;
        if (len > MAX_RUN) len = MAX_RUN;
        return len;
    endfunction

    initial begin : stimulus
        logic [CFG_W-1:0] ign;
        logic [CFG_W-1:0] fst;
        logic [CFG_W-1:0] slw;
        logic [CFG_W-1:0] tol;
        logic [CFG_W-1:0] stdy;
        logic             lvl;
        int               sent;
        int               len;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. With the reset registers both level changes come far
        // too soon after reset and must be ignored.
        send_tick(1'b0);
        send_tick(1'b1);
        drain();

        // Small registers so that each case fits in a handful of ticks: a fast
        // pulse, a slow pulse, a glitch whose return edge is dropped, a pulse
        // that matches neither period (off by exactly the tolerance), and a
        // quiet stretch long enough to report steady on.
        program_registers(16'd1, 16'd3, 16'd6, 16'd1, 16'd5, 1'b1);
        send_run(1'b0, 3);
        send_run(1'b1, 6);
        send_run(1'b0, 1);
        send_run(1'b1, 4);
        send_run(1'b0, 8);
        lvl = 1'b0;

        // Random part, one register setting per phase.
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: begin
                    // Zero tolerance: no pulse can ever be classified.
                    ign  = CFG_W'($urandom_range(0, 3));
                    fst  = CFG_W'($urandom_range(3, 8));
                    slw  = CFG_W'($urandom_range(12, 24));
                    tol  = '0;
                    stdy = CFG_W'($urandom_range(10, 30));
                end
                1: begin
                    ign  = '0;
                    fst  = '0;
                    slw  = '0;
                    tol  = '0;
                    stdy = '0;
                end
                2: begin
                    ign  = REG_MAX;
                    fst  = REG_MAX;
                    slw  = REG_MAX;
                    tol  = REG_MAX;
                    stdy = REG_MAX;
                end
                3: begin
                    // Every accepted pulse falls in the fast window.
                    ign  = '0;
                    fst  = CFG_W'($urandom_range(3, 8));
                    slw  = CFG_W'($urandom_range(12, 24));
                    tol  = REG_MAX;
                    stdy = CFG_W'($urandom_range(10, 30));
                end
                default: begin
                    ign  = pick_reg(0, 5);
                    fst  = pick_reg(2, 12);
                    slw  = pick_reg(10, 40);
                    tol  = pick_reg(1, 4);
                    stdy = pick_reg(8, 50);
                end
            endcase
            program_registers(ign, fst, slw, tol, stdy, (p % 3) == 0);

            if (p == PHASES - 1) begin
                calm_tail   <= 1'b1;
                sender_gaps = 1'b0;
            end
            if (p == SQUEEZE_PHASE) begin
                hold_requests <= hold_requests + 1;
                sender_gaps   = 1'b0;
            end

            sent = 0;
            while (sent < TICKS_PER_PHASE) begin
                len = pick_run_len(ign, fst, slw, tol, stdy);
                if (len > TICKS_PER_PHASE - sent) len = TICKS_PER_PHASE - sent;
                lvl = ~lvl;
                send_run(lvl, len);
                sent += len;
                if (p == SQUEEZE_PHASE && sent >= SQUEEZE_TICKS) sender_gaps = 1'b1;
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/led_brc_pkg.sv
rtl/led_brc_cfg.sv
rtl/led_brc_step.sv
rtl/led_blink_rate_classifier.sv
tb/led_brc_checker.sv
tb/tb_top.sv
